>>> design/fqc_pkg.sv
// ----------------------------------------------------------------------------
// fqc_pkg
// command and status codes and fixed field widths for the cancellable queue
// ----------------------------------------------------------------------------
`default_nettype none

package fqc_pkg;

    // fixed widths of the word fields
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int ITEM_W   = 16;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;

    // command codes
    localparam cmd_t CMD_ENQ    = 2'd0;
    localparam cmd_t CMD_DEQ    = 2'd1;
    localparam cmd_t CMD_CANCEL = 2'd2;

    // status codes
    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;

endpackage

`default_nettype wire

>>> design/fqc_ram.sv
// ----------------------------------------------------------------------------
// fqc_ram
// entry store: one write port, one read port, registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module fqc_ram #(
    parameter int DEPTH  = 16,
    parameter int WIDTH  = 16,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

>>> design/fifo_queue_with_cancel_unit.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_cancel_unit
// bounded fifo of identifiers with enqueue, dequeue and cancel-by-value
// ----------------------------------------------------------------------------
// usage
//   input channel (in_valid/in_ready) carries one command word: cmd and
//   item_id. output channel (out_valid/out_ready) returns exactly one result
//   word per command: status, head_id, removed_count and occupancy.
//   entries live in a ring buffer held in a synchronous ram with registered
//   read data; a head pointer, a tail pointer and a fill count track it.
// sequencing
//   enqueue, and any command that finds nothing to do: the result is
//   registered on acceptance. dequeue: one ram read, result from S_DEQ.
//   cancel: streams every held entry through the single ram read port in
//   S_CANCEL and writes survivors back in place, compacted.
//   one command is worked on at a time.
// reset
//   rst_n clears pointers, count and the output valid flag; the ram itself is
//   not cleared and is only ever read at entries that were written.
// back-pressure
//   the result sits in an output register; a new command is taken while the
//   previous result is still held, as long as it is being taken this cycle
//   or the register is empty. a stalled receiver therefore stops intake.
// ----------------------------------------------------------------------------
`default_nettype none

module fifo_queue_with_cancel_unit
    import fqc_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_WIDTH    = 16,
    localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    // command channel
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [CMD_W-1:0]  cmd,
    input  wire logic [ITEM_W-1:0] item_id,
    // result channel
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [STATUS_W-1:0]    status,
    output logic [ITEM_W-1:0]      head_id,
    output logic [CNT_W-1:0]       removed_count,
    output logic [CNT_W-1:0]       occupancy
);

    // stored identifier width: the port only brings 16 bits
    localparam int SID_W = (ID_WIDTH < ITEM_W) ? ID_WIDTH : ITEM_W;
    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    // sequencer states
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_DEQ    = 2'd1;
    localparam logic [1:0] S_CANCEL = 2'd2;

    // ring pointer step with wrap for any depth
    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == LAST_PTR) ? '0 : p + 1'b1;
    endfunction

    logic [1:0]       state_reg,   state_next;
    logic [PTR_W-1:0] head_reg,    head_next;
    logic [PTR_W-1:0] tail_reg,    tail_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    // cancel sweep
    logic [PTR_W-1:0] rd_slot_reg, rd_slot_next;
    logic [PTR_W-1:0] wr_slot_reg, wr_slot_next;
    logic [CNT_W-1:0] kept_reg,    kept_next;
    logic [CNT_W-1:0] proc_reg,    proc_next;
    logic [SID_W-1:0] cid_reg,     cid_next;
    // output register
    logic                 out_valid_reg, out_valid_next;
    status_t              status_reg,    status_next;
    logic [ITEM_W-1:0]    head_id_reg,   head_id_next;
    logic [CNT_W-1:0]     removed_reg,   removed_next;
    logic [CNT_W-1:0]     occ_reg,       occ_next;

    // ram ports
    logic             ram_we;
    logic [PTR_W-1:0] ram_waddr;
    logic [SID_W-1:0] ram_wdata;
    logic             ram_re;
    logic [PTR_W-1:0] ram_raddr;
    logic [SID_W-1:0] ram_rdata;

    logic             accept;
    logic [SID_W-1:0] id_in;
    logic             keep;
    logic [CNT_W-1:0] kept_upd;
    logic [PTR_W-1:0] wr_slot_upd;
    logic             sweep_last;

    fqc_ram #(
        .DEPTH  (QUEUE_DEPTH),
        .WIDTH  (SID_W),
        .ADDR_W (PTR_W)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // intake only when idle and the output register frees up this cycle
    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign id_in    = item_id[SID_W-1:0];

    // cancel sweep: ram data is the entry at offset proc_reg
    assign keep        = (ram_rdata != cid_reg);
    assign kept_upd    = kept_reg + CNT_W'(keep);
    assign wr_slot_upd = keep ? ptr_inc(wr_slot_reg) : wr_slot_reg;
    assign sweep_last  = ((proc_reg + 1'b1) == count_reg);

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        rd_slot_next = rd_slot_reg;
        wr_slot_next = wr_slot_reg;
        kept_next    = kept_reg;
        proc_next    = proc_reg;
        cid_next     = cid_reg;

        status_next    = status_reg;
        head_id_next   = head_id_reg;
        removed_next   = removed_reg;
        occ_next       = occ_reg;
        out_valid_next = out_valid_reg && !out_ready;

        ram_we    = 1'b0;
        ram_waddr = tail_reg;
        ram_wdata = id_in;
        ram_re    = 1'b0;
        ram_raddr = head_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    status_next  = ST_OK;
                    head_id_next = '0;
                    removed_next = '0;
                    occ_next     = count_reg;
                    case (cmd)
                        CMD_ENQ:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg == DEPTH_CNT)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = tail_reg;
                                ram_wdata  = id_in;
                                tail_next  = ptr_inc(tail_reg);
                                count_next = count_reg + 1'b1;
                                occ_next   = count_reg + 1'b1;
                            end
                        end
                        CMD_DEQ:
                        begin
                            if (count_reg == '0)
                            begin
                                status_next    = ST_EMPTY;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                ram_re     = 1'b1;
                                ram_raddr  = head_reg;
                                head_next  = ptr_inc(head_reg);
                                count_next = count_reg - 1'b1;
                                state_next = S_DEQ;
                            end
                        end
                        CMD_CANCEL:
                        begin
                            if (count_reg == '0)
                            begin
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                ram_re       = 1'b1;
                                ram_raddr    = head_reg;
                                rd_slot_next = ptr_inc(head_reg);
                                wr_slot_next = head_reg;
                                kept_next    = '0;
                                proc_next    = '0;
                                cid_next     = id_in;
                                state_next   = S_CANCEL;
                            end
                        end
                        default:
                        begin
                            // unused code: no-op with a plain ok result
                            out_valid_next = 1'b1;
                        end
                    endcase
                end
            end
            S_DEQ:
            begin
                status_next    = ST_OK;
                head_id_next   = ITEM_W'(ram_rdata);
                removed_next   = CNT_W'(1);
                occ_next       = count_reg;
                out_valid_next = 1'b1;
                state_next     = S_IDLE;
            end
            S_CANCEL:
            begin
                // survivors are written back at the compacted slot
                ram_we       = keep;
                ram_waddr    = wr_slot_reg;
                ram_wdata    = ram_rdata;
                wr_slot_next = wr_slot_upd;
                kept_next    = kept_upd;
                proc_next    = proc_reg + 1'b1;
                if (!sweep_last)
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = rd_slot_reg;
                    rd_slot_next = ptr_inc(rd_slot_reg);
                end
                else
                begin
                    count_next     = kept_upd;
                    tail_next      = wr_slot_upd;
                    status_next    = ST_OK;
                    head_id_next   = '0;
                    removed_next   = count_reg - kept_upd;
                    occ_next       = kept_upd;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // sweep and result payload
    always_ff @(posedge clk)
    begin
        rd_slot_reg <= rd_slot_next;
        wr_slot_reg <= wr_slot_next;
        kept_reg    <= kept_next;
        proc_reg    <= proc_next;
        cid_reg     <= cid_next;
        status_reg  <= status_next;
        head_id_reg <= head_id_next;
        removed_reg <= removed_next;
        occ_reg     <= occ_next;
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign head_id       = head_id_reg;
    assign removed_count = removed_reg;
    assign occupancy     = occ_reg;

    // ------------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------------

    logic [CNT_W:0] tail_sum;
    assign tail_sum = {1'b0, CNT_W'(head_reg)} + {1'b0, count_reg};

    // fill count never exceeds the depth
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("fill count above depth");

    // tail pointer stays head plus count, modulo depth, between commands
    a_tail_track: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |->
            ((tail_sum >= (CNT_W+1)'(QUEUE_DEPTH))
                ? (tail_reg == PTR_W'(tail_sum - (CNT_W+1)'(QUEUE_DEPTH)))
                : (tail_reg == PTR_W'(tail_sum))))
        else $error("tail pointer out of step with head and count");

    // compaction never writes ahead of the read sweep
    a_kept_le_proc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CANCEL) |-> (kept_reg <= proc_reg) && (proc_reg < count_reg))
        else $error("cancel sweep bookkeeping broken");

    // an accepted enqueue answers in the next cycle
    a_enq_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_ENQ)) |=> out_valid_reg)
        else $error("enqueue result missing");

endmodule

`default_nettype wire
